// ----- sv/sfrs_pkg.sv -----
package sfrs_pkg;

	localparam int SFRS_FLAP_COUNT        = 256;
	localparam int SFRS_MAX_MODULES       = 64;
	localparam int SFRS_DEFAULT_CAP       = 8;
	localparam int SFRS_DEFAULT_FLAP_TIME = 60;

	localparam int ADDR_W = 4;

	localparam logic [1:0] REG_FLAP_CAP     = 2'd0;
	localparam logic [1:0] REG_FLAP_TIME    = 2'd1;
	localparam logic [1:0] REG_MODULE_COUNT = 2'd2;

	localparam logic [6:0] MODULE_COUNT_RESET = 7'd64;

	localparam logic CMD_SET  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic        command;
		logic [5:0]  module_req;
		logic [9:0]  flap;
		logic [31:0] time_ms;
	} sfrs_in_t;

	typedef struct packed {
		logic [5:0] module_id;
		logic [7:0] position;
		logic       mid_flip;
		logic       moving;
		logic       stepped;
		logic       last;
	} sfrs_out_t;

endpackage

// ----- sv/sfrs_table.sv -----
module sfrs_table #(
	parameter int DEPTH = sfrs_pkg::SFRS_MAX_MODULES,
	parameter int DW    = 50,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0]    mem_q [DEPTH];
	logic [DW-1:0]    rd_q;
	logic [DEPTH-1:0] written_q;
	logic             rd_ok_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	// an entry never written reads as its reset value, all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_ok_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			rd_ok_q <= written_q[rd_addr];
		end
	end

	assign rd_data = rd_ok_q ? rd_q : '0;

endmodule

// ----- sv/split_flap_reel_stepper.sv -----
// Set-target item: accepted only while idle; result loads through the READ and CALC states.
// Tick item: one result per module in use (table read, then modify and write back), and
// the input stays stalled until the last module's result is loaded.
// Results go one at a time through the single read port of the module table; output stalls hold them.
// Reset (arst_n low) clears control, configuration and per-entry written bits at once;
// entries never written read as homed and at rest, so there is no clearing pass.
module split_flap_reel_stepper #(
	parameter int FLAP_COUNT        = sfrs_pkg::SFRS_FLAP_COUNT,
	parameter int MAX_MODULES       = sfrs_pkg::SFRS_MAX_MODULES,
	parameter int DEFAULT_CAP       = sfrs_pkg::SFRS_DEFAULT_CAP,
	parameter int DEFAULT_FLAP_TIME = sfrs_pkg::SFRS_DEFAULT_FLAP_TIME
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sfrs_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  sfrs_pkg::sfrs_in_t          cmd,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output sfrs_pkg::sfrs_out_t         rsp
);

	import sfrs_pkg::*;

	localparam int PW  = $clog2(FLAP_COUNT);
	localparam int PW1 = PW + 1;
	localparam int IW  = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;

	localparam logic [PW:0]   F_EXT    = PW1'(FLAP_COUNT);
	localparam logic [PW-1:0] POS_LAST = PW'(FLAP_COUNT - 1);

	typedef struct packed {
		logic          valid;
		logic          phase;
		logic [PW-1:0] pos;
		logic [PW-1:0] tgt;
		logic [31:0]   due_time;
	} entry_t;

	localparam int DW = $bits(entry_t);

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CALC} state_t;

	// configuration
	logic [7:0]  flap_cap_q;
	logic [15:0] flap_time_q;
	logic [6:0]  module_count_q;
	logic [1:0]  reg_idx;

	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flap_cap_q     <= '0;
			flap_time_q    <= '0;
			module_count_q <= MODULE_COUNT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_FLAP_CAP:     flap_cap_q     <= pwdata[7:0];
				REG_FLAP_TIME:    flap_time_q    <= pwdata[15:0];
				REG_MODULE_COUNT: module_count_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FLAP_CAP:     prdata = 32'(flap_cap_q);
			REG_FLAP_TIME:    prdata = 32'(flap_time_q);
			REG_MODULE_COUNT: prdata = 32'(module_count_q);
			default:          prdata = '0;
		endcase
	end

	// effective settings
	logic [6:0]  cnt;
	logic [7:0]  cap_eff;
	logic [15:0] ft_eff;
	logic [14:0] half;

	always_comb begin
		if (module_count_q == 7'd0) begin
			cnt = 7'd1;
		end else if (module_count_q > 7'(MAX_MODULES)) begin
			cnt = 7'(MAX_MODULES);
		end else begin
			cnt = module_count_q;
		end
		cap_eff = (flap_cap_q == 8'd0) ? 8'(DEFAULT_CAP) : flap_cap_q;
		ft_eff  = (flap_time_q == 16'd0) ? 16'(DEFAULT_FLAP_TIME) : flap_time_q;
		half    = (ft_eff[15:1] == 15'd0) ? 15'd1 : ft_eff[15:1];
	end

	state_t          state_q;
	sfrs_in_t        item_q;
	logic [IW-1:0]   idx_q;
	logic            rsp_valid_q;
	sfrs_out_t       rsp_q;

	logic [DW-1:0] rd_data;
	entry_t        e;
	entry_t        nxt;
	sfrs_out_t     res;
	logic          wr_need;
	logic          out_free;
	logic          last_idx;
	logic          in_use;
	logic          req_in_use;
	logic          flap_ok;
	logic          due;
	logic [PW-1:0] flap_pw;
	logic [PW-1:0] pos_inc;
	logic [PW:0]   diff;
	logic [PW:0]   fwd_dist;
	logic [PW:0]   np_raw;
	logic [PW:0]   np;
	logic [31:0]   lag;

	assign e          = entry_t'(rd_data);
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign last_idx   = (7'(idx_q) == (cnt - 7'd1));
	assign in_use     = ({1'b0, item_q.module_req} < cnt);
	assign req_in_use = ({1'b0, cmd.module_req} < cnt);
	assign flap_ok    = (item_q.flap < 10'(FLAP_COUNT));
	assign flap_pw    = item_q.flap[PW-1:0];

	// forward distance and capped start, each reduced by one compare and subtract
	always_comb begin
		diff     = {1'b0, flap_pw} + F_EXT - {1'b0, e.pos};
		fwd_dist = (diff >= F_EXT) ? (diff - F_EXT) : diff;
		np_raw   = {1'b0, flap_pw} + F_EXT - PW1'(cap_eff);
		np       = (np_raw >= F_EXT) ? (np_raw - F_EXT) : np_raw;
		pos_inc  = (e.pos == POS_LAST) ? '0 : (e.pos + PW'(1));
		lag      = item_q.time_ms - e.due_time;
		due      = e.valid && !lag[31];
	end

	always_comb begin
		nxt     = e;
		res     = '0;
		wr_need = 1'b0;
		if (item_q.command == CMD_SET) begin
			res.module_id = item_q.module_req;
			res.last      = 1'b1;
			if (in_use) begin
				if (!flap_ok) begin
					res.position = 8'(e.pos);
					res.mid_flip = e.phase;
					res.moving   = e.valid;
				end else begin
					wr_need   = 1'b1;
					nxt.phase = 1'b0;
					if (flap_pw == e.pos) begin
						nxt.valid = 1'b0;
					end else begin
						if (9'(fwd_dist) > {1'b0, cap_eff}) begin
							nxt.pos = np[PW-1:0];
						end
						nxt.tgt      = flap_pw;
						nxt.valid    = 1'b1;
						nxt.due_time = item_q.time_ms;
					end
					res.position = 8'(nxt.pos);
					res.mid_flip = nxt.phase;
					res.moving   = nxt.valid;
					res.stepped  = 1'b1;
				end
			end
		end else begin
			res.module_id = 6'(idx_q);
			res.last      = last_idx;
			if (due) begin
				wr_need = 1'b1;
				if (!e.phase) begin
					nxt.phase = 1'b1;
				end else begin
					nxt.pos   = pos_inc;
					nxt.phase = 1'b0;
					if (pos_inc == e.tgt) begin
						nxt.valid = 1'b0;
					end
				end
				nxt.due_time = item_q.time_ms + 32'(half);
				res.stepped  = 1'b1;
			end
			res.position = 8'(nxt.pos);
			res.mid_flip = nxt.phase;
			res.moving   = nxt.valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			item_q      <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// load a new beat, else drop the one taken, else hold
			if (state_q == ST_CALC && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						item_q  <= cmd;
						// out-of-use requests park on entry 0 and never write
						idx_q   <= (cmd.command == CMD_SET && req_in_use) ?
						           IW'(cmd.module_req) : '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_CALC;
				ST_CALC: begin
					if (out_free) begin
						rsp_q <= res;
						if (item_q.command == CMD_TICK && !last_idx) begin
							idx_q   <= idx_q + IW'(1);
							state_q <= ST_READ;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	sfrs_table #(
		.DEPTH(MAX_MODULES),
		.DW   (DW),
		.AW   (IW)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_addr(idx_q),
		.rd_data(rd_data),
		.wr_en  (state_q == ST_CALC && out_free && wr_need),
		.wr_addr(idx_q),
		.wr_data(DW'(nxt))
	);

	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- sv/sfrs_checker.sv -----
module sfrs_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_stall,
	input sfrs_pkg::sfrs_in_t  cmd,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input sfrs_pkg::sfrs_out_t rsp
);

	import sfrs_pkg::*;

	// a held beat keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("input accepted while an item is in progress");

	// a tick is still walking while a non-final beat is shown
	a_busy_mid_tick: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> cmd_stall)
		else $error("input open in the middle of a tick");

	// tick beats come in module order
	a_tick_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && !rsp.last |=>
		!rsp_valid || (rsp.module_id == 6'($past(rsp.module_id) + 6'd1)))
		else $error("tick beats out of module order");

endmodule

bind split_flap_reel_stepper sfrs_checker u_sfrs_checker (.*);

// ----- sim/tb_split_flap_reel_stepper.sv -----
module tb_split_flap_reel_stepper;

	import sfrs_pkg::*;

	localparam int RAND_PHASES = 6;
	localparam int PHASE_BEATS = 24;
	localparam int LONG_HOLD   = 320;

	typedef enum int {PACE_FLOW, PACE_LIGHT, PACE_HEAVY, PACE_PERIODIC} pace_t;

	// Mirror of the module table; predicts the result beats of every accepted command.
	class reel_table_checker;
		logic [7:0]  cap_reg;
		logic [15:0] ftime_reg;
		logic [6:0]  count_reg;
		logic [7:0]  reel_pos  [SFRS_MAX_MODULES];
		logic [7:0]  target    [SFRS_MAX_MODULES];
		bit          target_on [SFRS_MAX_MODULES];
		bit          mid       [SFRS_MAX_MODULES];
		logic [31:0] due_at    [SFRS_MAX_MODULES];
		sfrs_out_t   reports_due [$];
		int          errors;
		int          n_sets;
		int          n_ticks;
		int          n_reports;
		int          n_half_steps;

		function new();
			cap_reg   = '0;
			ftime_reg = '0;
			count_reg = MODULE_COUNT_RESET;
			foreach (reel_pos[i]) begin
				reel_pos[i]  = '0;
				target[i]    = '0;
				target_on[i] = 1'b0;
				mid[i]       = 1'b0;
				due_at[i]    = '0;
			end
			errors       = 0;
			n_sets       = 0;
			n_ticks      = 0;
			n_reports    = 0;
			n_half_steps = 0;
		endfunction

		function int modules_used();
			if (count_reg == 0)
				return 1;
			if (count_reg > SFRS_MAX_MODULES)
				return SFRS_MAX_MODULES;
			return int'(count_reg);
		endfunction

		function int half_wait();
			int h;
			h = ((ftime_reg != 0) ? int'(ftime_reg) : SFRS_DEFAULT_FLAP_TIME) / 2;
			return (h == 0) ? 1 : h;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
			REG_FLAP_CAP: begin
				cap_reg = val[7:0];
			end
			REG_FLAP_TIME: begin
				ftime_reg = val[15:0];
			end
			REG_MODULE_COUNT: begin
				count_reg = val[6:0];
			end
			default: begin
			end
			endcase
		endfunction

		function logic [31:0] reg_value(logic [1:0] idx);
			case (idx)
			REG_FLAP_CAP:     return {24'd0, cap_reg};
			REG_FLAP_TIME:    return {16'd0, ftime_reg};
			REG_MODULE_COUNT: return {25'd0, count_reg};
			default:          return '0;
			endcase
		endfunction

		function void take_command(sfrs_in_t c);
			sfrs_out_t   r;
			int          cnt;
			int          cap;
			int          m;
			logic [7:0]  fwd_dist;
			logic [31:0] lag;
			cnt = modules_used();
			if (c.command == CMD_SET) begin
				n_sets++;
				m = int'(c.module_req);
				r = '0;
				r.module_id = c.module_req;
				r.last = 1'b1;
				if (m < cnt && c.flap >= SFRS_FLAP_COUNT) begin
					// out-of-range flap: report, leave the module alone
					r.position = reel_pos[m];
					r.mid_flip = mid[m];
					r.moving   = target_on[m];
				end else if (m < cnt) begin
					if (c.flap[7:0] == reel_pos[m]) begin
						target_on[m] = 1'b0;
						mid[m]       = 1'b0;
					end else begin
						fwd_dist = c.flap[7:0] - reel_pos[m];
						cap  = (cap_reg != 0) ? int'(cap_reg) : SFRS_DEFAULT_CAP;
						// long jump: snap to cap flaps short of the destination
						if (fwd_dist > cap)
							reel_pos[m] = c.flap[7:0] - 8'(cap);
						target[m]    = c.flap[7:0];
						target_on[m] = 1'b1;
						mid[m]       = 1'b0;
						due_at[m]    = c.time_ms;
					end
					r.position = reel_pos[m];
					r.mid_flip = mid[m];
					r.moving   = target_on[m];
					r.stepped  = 1'b1;
				end
				reports_due.push_back(r);
			end else begin
				n_ticks++;
				for (int i = 0; i < cnt; i++) begin
					r = '0;
					lag = c.time_ms - due_at[i];
					if (target_on[i] && !lag[31]) begin
						if (!mid[i]) begin
							mid[i] = 1'b1;
						end else begin
							reel_pos[i] = reel_pos[i] + 8'd1;
							mid[i] = 1'b0;
							if (reel_pos[i] == target[i])
								target_on[i] = 1'b0;
						end
						due_at[i] = c.time_ms + 32'(half_wait());
						r.stepped = 1'b1;
						n_half_steps++;
					end
					r.module_id = 6'(i);
					r.position  = reel_pos[i];
					r.mid_flip  = mid[i];
					r.moving    = target_on[i];
					r.last      = (i == cnt - 1);
					reports_due.push_back(r);
				end
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 30)
				$display("MISMATCH: %s", msg);
		endtask

		task check_report(sfrs_out_t got);
			sfrs_out_t want;
			string     diff;
			n_reports++;
			if (reports_due.size() == 0) begin
				report($sformatf("beat %0d unexpected: module %0d pos %0d",
					n_reports, got.module_id, got.position));
				return;
			end
			want = reports_due.pop_front();
			diff = "";
			if (got.module_id !== want.module_id)
				diff = {diff, $sformatf(" module_id %0d/%0d", got.module_id, want.module_id)};
			if (got.position !== want.position)
				diff = {diff, $sformatf(" position %0d/%0d", got.position, want.position)};
			if (got.mid_flip !== want.mid_flip)
				diff = {diff, $sformatf(" mid_flip %b/%b", got.mid_flip, want.mid_flip)};
			if (got.moving !== want.moving)
				diff = {diff, $sformatf(" moving %b/%b", got.moving, want.moving)};
			if (got.stepped !== want.stepped)
				diff = {diff, $sformatf(" stepped %b/%b", got.stepped, want.stepped)};
			if (got.last !== want.last)
				diff = {diff, $sformatf(" last %b/%b", got.last, want.last)};
			if (diff != "")
				report($sformatf("beat %0d (got/want):%s", n_reports, diff));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                cmd_valid;
	logic                cmd_stall;
	sfrs_in_t            cmd;
	logic                rsp_valid;
	logic                rsp_stall;
	sfrs_out_t           rsp;

	reel_table_checker   sb;
	sfrs_in_t            stim_q [$];
	logic [31:0]         now_ms;
	bit                  hold_wanted = 1'b0;
	bit                  hold_done = 1'b0;

	split_flap_reel_stepper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#8000000;
		$display("Mismatches found");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_report(rsp);
	end

	// Output pacing: free flow, light and heavy random stalls, periodic stalls,
	// plus one long hold-off when asked for.
	initial begin : rsp_pacing
		pace_t mode;
		int    span;
		int    period;
		rsp_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_wanted && !hold_done) begin
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
			end
			mode   = pace_t'($urandom_range(0, 3));
			span   = $urandom_range(8, 90);
			period = $urandom_range(2, 5);
			for (int k = 0; k < span; k++) begin
				case (mode)
				PACE_FLOW:     rsp_stall <= 1'b0;
				PACE_LIGHT:    rsp_stall <= ($urandom_range(0, 4) == 0);
				PACE_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
				PACE_PERIODIC: rsp_stall <= (k % period == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	function sfrs_in_t set_beat(int m, int f, logic [31:0] t);
		sfrs_in_t c;
		c.command    = CMD_SET;
		c.module_req = 6'(m);
		c.flap       = 10'(f);
		c.time_ms    = t;
		return c;
	endfunction

	function sfrs_in_t tick_beat(logic [31:0] t);
		sfrs_in_t c;
		c = '0;
		c.command = CMD_TICK;
		c.time_ms = t;
		return c;
	endfunction

	task apb_write(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.write_reg(idx, val);
		// read back through a fresh setup phase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== sb.reg_value(idx))
			sb.report($sformatf("register %0d reads %0h, want %0h",
				idx, prdata, sb.reg_value(idx)));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task configure(input int cap, input int ftime, input int count);
		apb_write(REG_FLAP_CAP, 32'(cap));
		apb_write(REG_FLAP_TIME, 32'(ftime));
		apb_write(REG_MODULE_COUNT, 32'(count));
	endtask

	// Offer the queued commands in bursts with random gaps.
	task drive_stim();
		int burst;
		int gap;
		burst = 0;
		while (stim_q.size() > 0) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 12);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					cmd_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			cmd       <= stim_q[0];
			cmd_valid <= 1'b1;
			@(posedge clk);
			while (cmd_stall) @(posedge clk);
			sb.take_command(stim_q.pop_front());
			burst--;
		end
		cmd_valid <= 1'b0;
	endtask

	task drain();
		while (sb.reports_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly ticks that walk time forward near the step rate, plus targets;
	// a few ticks jump back or anywhere.
	task fill_phase(input int n);
		int cnt;
		int half;
		int r;
		int m;
		int f;
		cnt  = sb.modules_used();
		half = sb.half_wait();
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, cnt - 1);
				f = ($urandom_range(0, 11) == 0) ? $urandom_range(256, 1023) : $urandom_range(0, 255);
				stim_q.push_back(set_beat(m, f, now_ms));
			end else if (r < 92) begin
				now_ms = now_ms + 32'($urandom_range(0, 2 * half + 1));
				stim_q.push_back(tick_beat(now_ms));
			end else if (r < 96) begin
				stim_q.push_back(tick_beat(now_ms - 32'($urandom_range(1, 4 * half))));
			end else begin
				stim_q.push_back(tick_beat($urandom));
			end
		end
	endtask

	initial begin
		int          cap_set   [RAND_PHASES];
		int          time_set  [RAND_PHASES];
		int          count_set [RAND_PHASES];
		logic [31:0] t0;
		cap_set   = '{0, 255, 1, 8, 0, 37};
		time_set  = '{0, 1, 65535, 7, 0, 2};
		count_set = '{8, 3, 64, 127, 0, 1};
		arst_n    <= 1'b0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		cmd_valid <= 1'b0;
		cmd       <= '0;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: default cap and flap time, all modules in use
		t0 = 32'h0000_0100;
		stim_q.push_back(set_beat(0, 0, t0));       // current flap: clears target
		stim_q.push_back(set_beat(63, 255, t0));    // long jump, snapped short
		stim_q.push_back(set_beat(5, 1023, t0));    // flap out of range
		stim_q.push_back(set_beat(5, 256, t0));
		stim_q.push_back(set_beat(1, 3, t0));       // short walk
		stim_q.push_back(tick_beat(t0));
		stim_q.push_back(tick_beat(t0 + 29));       // not yet due
		stim_q.push_back(tick_beat(t0 + 30));
		stim_q.push_back(set_beat(1, 1, t0 + 31));  // stop on the flap it shows
		stim_q.push_back(tick_beat(t0 + 60));
		drive_stim();
		drain();

		// widest cap, shortest step, count of zero acts as one module
		configure(255, 1, 0);
		stim_q.push_back(set_beat(1, 7, 32'd5));    // module out of use
		stim_q.push_back(set_beat(0, 200, 32'hFFFF_FFFE));
		stim_q.push_back(tick_beat(32'hFFFF_FFFE));
		stim_q.push_back(tick_beat(32'hFFFF_FFFF));
		stim_q.push_back(tick_beat(32'h0000_0000)); // time wraps
		stim_q.push_back(tick_beat(32'h0000_0001));
		stim_q.push_back(tick_beat(32'h8000_0000));
		stim_q.push_back(tick_beat(32'h0000_0010)); // far behind: not due
		stim_q.push_back(set_beat(0, 0, 32'h0000_0020));
		drive_stim();
		drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p == 4) begin
				cap_set[p]   = $urandom_range(0, 255);
				time_set[p]  = $urandom_range(0, 65535);
				count_set[p] = $urandom_range(1, 16);
			end
			configure(cap_set[p], time_set[p], count_set[p]);
			now_ms = (p == 3) ? 32'hFFFF_FF80 : $urandom;
			fill_phase(PHASE_BEATS);
			// all modules in use: hold the output long enough to back up the input
			if (p == 2)
				hold_wanted = 1'b1;
			drive_stim();
			drain();
		end

		repeat (2 * SFRS_MAX_MODULES + 12) @(posedge clk);
		$display("Covered %0d set-target and %0d tick beats; %0d result beats, %0d half steps.",
			sb.n_sets, sb.n_ticks, sb.n_reports, sb.n_half_steps);
		$display("Swept cap, flap time and module count through their extremes; long hold %s.",
			hold_done ? "applied" : "not reached");
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- files.f -----
sv/sfrs_pkg.sv
sv/sfrs_table.sv
sv/split_flap_reel_stepper.sv
sv/sfrs_checker.sv
sim/tb_split_flap_reel_stepper.sv
